// ----- rtl/mei_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mei_pkg: shared constants and types
// Fixed-point widths and the controller/datapath command and status bundles.
// ---------------------------------------------------------------------------
package mei_pkg;

  localparam int FRAC_BITS   = 27;
  localparam int COUNT_WIDTH = 10;
  localparam int C_WIDTH     = 32;

  // z stays below 2^31 + 2^(FRAC_BITS+3) in magnitude after any update
  localparam int Z_MAG_BITS  = (C_WIDTH > FRAC_BITS + 3) ? C_WIDTH : FRAC_BITS + 3;
  localparam int Z_WIDTH     = Z_MAG_BITS + 2;

  // operands reach the multipliers only when |x|,|y| < 2.0
  localparam int MUL_WIDTH   = FRAC_BITS + 2;
  localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
  localparam int SQ_WIDTH    = PROD_WIDTH - FRAC_BITS;
  localparam int XY_WIDTH    = SQ_WIDTH + 1;
  localparam int SUM_WIDTH   = SQ_WIDTH + 1;

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(511);

  typedef struct packed {
    logic load;    // capture c, z = c, count = 0
    logic mul;     // register x^2, y^2, 2xy
    logic update;  // z = z^2 + c, count++
  } mei_cmd_t;

  typedef struct packed {
    logic range_esc;  // |x| or |y| >= 2
    logic at_limit;   // count reached max
    logic sum_esc;    // x^2 + y^2 >= 4
  } mei_stat_t;

endpackage
`default_nettype wire

// ----- rtl/mandelbrot_escape_iteration.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mandelbrot_escape_iteration: Mandelbrot escape-time counter
// Fixed-point Q4.27 point in, iteration count out; sequencer plus datapath.
// ---------------------------------------------------------------------------
// A point is taken when start is high and busy is low. Each iteration is a
// registered multiply through the three multipliers, then the escape test and
// z update. Once the point escapes or reaches the limit, its count is shown on
// out_iteration_count with out_valid high. The result is shown for exactly one
// cycle and cannot be held off; a new point may be started in that same cycle.
// cfg_ready is always high; write max_iterations only while busy is low.
// ---------------------------------------------------------------------------
module mandelbrot_escape_iteration
  import mei_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [C_WIDTH-1:0] in_c_real,
  input  wire logic signed [C_WIDTH-1:0] in_c_imag,
  output logic                           out_valid,
  output logic [COUNT_WIDTH-1:0]         out_iteration_count,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [COUNT_WIDTH-1:0]    cfg_max_iterations
);

  mei_cmd_t  cmd;
  mei_stat_t stat;

  assign cfg_ready = 1'b1;

  mei_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd),
    .stat  (stat)
  );

  mei_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .c_real             (in_c_real),
    .c_imag             (in_c_imag),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_max_iterations (cfg_max_iterations),
    .iteration_count    (out_iteration_count)
  );

endmodule
`default_nettype wire

// ----- rtl/mei_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mei_datapath: escape-time arithmetic
// Holds z, c, the iteration count and the limit register; squares and
// cross product are registered before the escape test and update.
// ---------------------------------------------------------------------------
module mei_datapath
  import mei_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mei_cmd_t                      cmd,
  output mei_stat_t                          stat,
  input  wire logic signed [C_WIDTH-1:0]     c_real,
  input  wire logic signed [C_WIDTH-1:0]     c_imag,
  input  wire logic                          cfg_we,
  input  wire logic [COUNT_WIDTH-1:0]        cfg_max_iterations,
  output logic [COUNT_WIDTH-1:0]             iteration_count
);

  localparam logic signed [Z_WIDTH-1:0]   ESC_POS = Z_WIDTH'(2) <<< FRAC_BITS;
  localparam logic signed [Z_WIDTH-1:0]   ESC_NEG = -ESC_POS;
  localparam logic signed [SUM_WIDTH-1:0] RADIUS_SQ = SUM_WIDTH'(4) <<< FRAC_BITS;

  logic [COUNT_WIDTH-1:0]         limit_r;
  logic [COUNT_WIDTH-1:0]         count_r;
  logic signed [C_WIDTH-1:0]      cx_r, cy_r;
  logic signed [Z_WIDTH-1:0]      x_r, y_r;
  logic signed [Z_WIDTH-1:0]      x_nxt, y_nxt;
  logic signed [SQ_WIDTH-1:0]     xx_r, yy_r;
  logic signed [XY_WIDTH-1:0]     xy2_r;
  logic signed [MUL_WIDTH-1:0]    xm, ym;
  logic signed [PROD_WIDTH-1:0]   prod_xx, prod_yy, prod_xy;
  logic signed [SUM_WIDTH-1:0]    sum_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_max_iterations;
    end
  end

  // operands are only meaningful when the range test passed
  assign xm = x_r[MUL_WIDTH-1:0];
  assign ym = y_r[MUL_WIDTH-1:0];

  assign prod_xx = xm * xm;
  assign prod_yy = ym * ym;
  assign prod_xy = xm * ym;

  // arithmetic shift of the exact product rounds toward minus infinity
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      xx_r  <= prod_xx[PROD_WIDTH-1:FRAC_BITS];
      yy_r  <= prod_yy[PROD_WIDTH-1:FRAC_BITS];
      xy2_r <= prod_xy[PROD_WIDTH-1:FRAC_BITS-1];
    end
  end

  assign x_nxt = Z_WIDTH'(xx_r) - Z_WIDTH'(yy_r) + Z_WIDTH'(cx_r);
  assign y_nxt = Z_WIDTH'(xy2_r) + Z_WIDTH'(cy_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= c_real;
      cy_r    <= c_imag;
      x_r     <= Z_WIDTH'(c_real);
      y_r     <= Z_WIDTH'(c_imag);
      count_r <= '0;
    end else if (cmd.update) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      count_r <= count_r + COUNT_WIDTH'(1);
    end
  end

  assign sum_sq = SUM_WIDTH'(xx_r) + SUM_WIDTH'(yy_r);

  assign stat.range_esc = (x_r >= ESC_POS) || (x_r <= ESC_NEG) ||
                          (y_r >= ESC_POS) || (y_r <= ESC_NEG);
  assign stat.at_limit  = (count_r >= limit_r);
  assign stat.sum_esc   = (sum_sq >= RADIUS_SQ);

  assign iteration_count = count_r;

endmodule
`default_nettype wire

// ----- rtl/mei_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mei_ctrl: iteration sequencer
// Alternates multiply and update steps until escape or the count limit,
// then strobes the result for one cycle.
// ---------------------------------------------------------------------------
module mei_ctrl
  import mei_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output logic           done,
  output mei_cmd_t       cmd,
  input  wire mei_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    cmd.load   = 1'b0;
    cmd.mul    = 1'b0;
    cmd.update = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat.at_limit || stat.range_esc) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (stat.sum_esc) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign done = done_r;

endmodule
`default_nettype wire

// ----- test/tb_mandelbrot_escape_iteration.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mandelbrot_escape_iteration: escape-time counter testbench
// Sends complex points with random gaps, predicts each iteration count with
// a fixed-point model of the z = z^2 + c loop, and checks every result
// strobe. Also steps max_iterations through several values, 0 and 1023 among them.
// ---------------------------------------------------------------------------
module tb_mandelbrot_escape_iteration
  import mei_pkg::*;
();

  localparam longint ESCAPE_EDGE = longint'(2) <<< FRAC_BITS;
  localparam longint RADIUS_SQ   = longint'(4) <<< FRAC_BITS;

  typedef struct {
    logic signed [C_WIDTH-1:0] c_real;
    logic signed [C_WIDTH-1:0] c_imag;
    logic [COUNT_WIDTH-1:0]    count;
  } point_count_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [C_WIDTH-1:0] in_c_real = '0;
  logic signed [C_WIDTH-1:0] in_c_imag = '0;
  logic                      out_valid;
  logic [COUNT_WIDTH-1:0]    out_iteration_count;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [COUNT_WIDTH-1:0]    cfg_max_iterations = '0;

  point_count_t           pending_counts[$];
  logic [COUNT_WIDTH-1:0] iter_limit = MAX_ITER_RESET;
  int                     mismatch_count = 0;
  bit                     burst = 1'b0;

  mandelbrot_escape_iteration dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_iterations  (cfg_max_iterations)
  );

  always #6 clk = ~clk;

  // squares floor-shifted by FRAC_BITS, 2xy by FRAC_BITS-1
  function automatic logic [COUNT_WIDTH-1:0] escape_count(
    input logic signed [C_WIDTH-1:0] cr,
    input logic signed [C_WIDTH-1:0] ci,
    input logic [COUNT_WIDTH-1:0]    lim
  );
    longint cx, cy, x, y, xx, yy, xy2;
    int     count;
    cx = longint'(cr);
    cy = longint'(ci);
    x = cx;
    y = cy;
    count = 0;
    while (count < int'(lim)) begin
      if ((x < 0 ? -x : x) >= ESCAPE_EDGE || (y < 0 ? -y : y) >= ESCAPE_EDGE) break;
      xx = (x * x) >>> FRAC_BITS;
      yy = (y * y) >>> FRAC_BITS;
      if (xx + yy >= RADIUS_SQ) break;
      xy2 = (x * y) >>> (FRAC_BITS - 1);
      x = xx - yy + cx;
      y = xy2 + cy;
      count++;
    end
    return count[COUNT_WIDTH-1:0];
  endfunction

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    point_count_t exp_pt;
    if (rst_n && out_valid) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0d", $time,
                 out_iteration_count);
        mismatch_count++;
      end else begin
        exp_pt = pending_counts.pop_front();
        if (out_iteration_count !== exp_pt.count) begin
          $display("%0t: count mismatch for c=(%h,%h): expected %0d, actual %0d",
                   $time, exp_pt.c_real, exp_pt.c_imag, exp_pt.count,
                   out_iteration_count);
          mismatch_count++;
        end
      end
    end
  end

  // settle: hold off the request until every pending count has come back
  task automatic drive_point(input logic signed [C_WIDTH-1:0] cr,
                             input logic signed [C_WIDTH-1:0] ci,
                             input bit settle = 1'b0);
    int unsigned  gap;
    point_count_t exp_pt;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap != 0 || (settle && (pending_counts.size() != 0 || busy !== 1'b0))) begin
      start <= 1'b0;
      if (settle)
        do @(posedge clk); while (pending_counts.size() != 0 || busy !== 1'b0);
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_c_real <= cr;
    in_c_imag <= ci;
    do @(posedge clk); while (busy !== 1'b0);
    exp_pt.c_real = cr;
    exp_pt.c_imag = ci;
    exp_pt.count  = escape_count(cr, ci, iter_limit);
    pending_counts.push_back(exp_pt);
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    while (pending_counts.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // only while idle
  task automatic write_max_iterations(input logic [COUNT_WIDTH-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_max_iterations <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    iter_limit = value;
  endtask

  // reset limit of 511: extremes, range and radius escapes, rounding, inside points
  task automatic test_directed_points();
    burst = 1'b1;
    drive_point(32'sh0000_0000, 32'sh0000_0000);
    drive_point(32'shF800_0000, 32'sh0000_0000);
    drive_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    drive_point(32'sh8000_0000, 32'sh8000_0000);
    drive_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    drive_point(32'shF000_0000, 32'sh0000_0000);
    drive_point(32'shF000_0001, 32'sh0000_0000);
    drive_point(32'sh0FFF_FFFF, 32'sh0000_0000);
    burst = 1'b0;
    drive_point(32'sh0000_0000, 32'sh0FFF_FFFF);
    drive_point(32'sh0000_0000, 32'shF000_0001);
    drive_point(32'sh0000_0000, 32'sh1000_0000);
    drive_point(32'sh0C00_0000, 32'sh0C00_0000);
    drive_point(32'sh0B50_4F33, 32'sh0B50_4F33);
    drive_point(32'sh0B50_4F34, 32'sh0B50_4F34);
    drive_point(32'sh0200_0000, 32'sh0000_0000);
    drive_point(32'shFFFF_FFFF, 32'sh0000_0001);
    drive_point(32'shFA00_0000, 32'sh00CC_CCCD);
    drive_point(32'sh0266_6666, 32'sh0400_0000, 1'b1);
    drive_point(32'shF200_0000, 32'sh0000_0000);
  endtask

  task automatic test_iteration_limits();
    burst = 1'b0;
    wait_results_done();
    write_max_iterations(10'd1023);
    drive_point(32'sh0000_0000, 32'sh0000_0000);
    drive_point(32'shF800_0000, 32'sh0000_0000);
    drive_point(32'sh0214_7AE1, 32'sh0000_0000);
    wait_results_done();
    write_max_iterations(10'd1);
    drive_point(32'sh0000_0000, 32'sh0000_0000);
    drive_point(32'sh0FFF_FFFF, 32'sh0000_0000);
    drive_point(32'sh0C00_0000, 32'sh0C00_0000);
    wait_results_done();
    write_max_iterations(10'd0);
    drive_point(32'sh0000_0000, 32'sh0000_0000);
    drive_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    drive_point(32'shF800_0000, 32'sh0000_0000);
  endtask

  // most points fall in the window around the set so counts spread out
  task automatic test_random_points();
    int unsigned               limits[12];
    int unsigned               lim, n_items;
    logic signed [C_WIDTH-1:0] cr, ci;
    limits = '{3, 1, 8, 64, 127, 255, 512, 1023, 20, 0, 0, 40};
    for (int p = 0; p < 12; p++) begin
      lim = (limits[p] == 0) ? $urandom_range(1, 127) : limits[p];
      n_items = (lim > 128) ? 30 : 100;
      burst = (p % 4 == 1);
      wait_results_done();
      write_max_iterations(lim[COUNT_WIDTH-1:0]);
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            cr = $urandom;
            ci = $urandom;
          end
          2: begin
            cr = $signed($urandom_range(0, 32'h2800_0000)) - 32'sh1400_0000;
            ci = $signed($urandom_range(0, 32'h2800_0000)) - 32'sh1400_0000;
          end
          default: begin
            cr = $signed($urandom_range(0, 32'h1800_0000)) - 32'sh1200_0000;
            ci = $signed($urandom_range(0, 32'h1800_0000)) - 32'sh0C00_0000;
          end
        endcase
        drive_point(cr, ci, $urandom_range(0, 31) == 0);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_iteration_limits();
    test_random_points();
    wait_results_done();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("[mandelbrot_escape_iteration] OK");
    else
      $display("[mandelbrot_escape_iteration] ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[mandelbrot_escape_iteration] ERROR");
    $finish;
  end

endmodule
